// ===== src/imu_tcf_pkg.sv =====
// Shared types, register codes and constants of the IMU tilt filter.
`default_nettype none

package imu_tcf_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFS_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFS_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_WEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_WEIGHT = 3'd7;

    localparam logic [15:0] GYRO_WEIGHT_RST  = 16'd32113;
    localparam logic [15:0] ACCEL_WEIGHT_RST = 16'd655;

    // CORDIC: angle accumulator in 2^-16 degree.
    localparam int CORDIC_STEPS = 18;
    localparam int ANG_W        = 26;
    localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd11796480;

    // Blend arithmetic.
    localparam int P_W       = 37;
    localparam int T_W       = 34;
    localparam int N_W       = 56;
    localparam logic [N_W-1:0] DT_DIV   = 56'd500000;
    localparam logic [N_W-1:0] DEN_HALF = 56'd8192000000;

    // The blend divisor is 2^20 * 15625. The numerator is shifted down by 20,
    // clamped to +-65536 * 15625 (still well past saturation), offset to be
    // positive and divided by 15625 with a reciprocal multiplication.
    localparam int DIV_STEPS = 2;
    localparam int M_W       = 36;
    localparam logic signed [M_W-1:0] M_HI = 36'sd1023999999;
    localparam logic signed [M_W-1:0] M_LO = -36'sd1024000000;
    localparam int U_W       = 31;
    localparam int RECIP_W   = 32;
    localparam logic [RECIP_W-1:0] RECIP = 32'd2251799814;
    localparam int RECIP_SH  = 45;
    localparam int Q_W       = 17;
    localparam logic [Q_W-1:0] Q_BIAS = 17'd65536;

    localparam int CNT_W = 5;

    typedef struct packed {
        logic             accept;
        logic             med_step;
        logic             roll_init;
        logic             roll_step;
        logic             sq_step;
        logic             pitch_init;
        logic             pitch_step;
        logic             bl0;
        logic             bl1;
        logic             bl2;
        logic             div_step;
        logic             commit;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [CNT_W-1:0] k);
        logic signed [ANG_W-1:0] v;
        case (k)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/imu_tcf_ctrl.sv =====
// Sequencing state machine of the IMU tilt filter.
`default_nettype none

module imu_tcf_ctrl #(
    parameter int MEDIAN_LENGTH = 11,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output imu_tcf_pkg::t_cmd   o_cmd
);
    import imu_tcf_pkg::*;

    localparam int RN = (SAMPLE_WIDTH > CORDIC_STEPS) ? SAMPLE_WIDTH : CORDIC_STEPS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MED   = 4'd1;
    localparam logic [3:0] S_RINIT = 4'd2;
    localparam logic [3:0] S_ROLL  = 4'd3;
    localparam logic [3:0] S_PINIT = 4'd4;
    localparam logic [3:0] S_PITCH = 4'd5;
    localparam logic [3:0] S_BL0   = 4'd6;
    localparam logic [3:0] S_BL1   = 4'd7;
    localparam logic [3:0] S_BL2   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.cnt  = r_cnt;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MED;
                    n_cnt        = '0;
                end
            end
            S_MED: begin
                o_cmd.med_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MEDIAN_LENGTH - 1)) begin
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                o_cmd.roll_init = 1'b1;
                n_state         = S_ROLL;
                n_cnt           = '0;
            end
            S_ROLL: begin
                o_cmd.roll_step = (r_cnt < CNT_W'(CORDIC_STEPS));
                o_cmd.sq_step   = (r_cnt < CNT_W'(SAMPLE_WIDTH));
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RN - 1)) begin
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                o_cmd.pitch_init = 1'b1;
                n_state          = S_PITCH;
                n_cnt            = '0;
            end
            S_PITCH: begin
                o_cmd.pitch_step = 1'b1;
                n_cnt            = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_BL0;
                end
            end
            S_BL0: begin
                o_cmd.bl0 = 1'b1;
                n_state   = S_BL1;
            end
            S_BL1: begin
                o_cmd.bl1 = 1'b1;
                n_state   = S_BL2;
            end
            S_BL2: begin
                o_cmd.bl2 = 1'b1;
                n_state   = S_DIV;
                n_cnt     = '0;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/imu_tcf_dp.sv =====
// Datapath of the IMU tilt filter: offsets, median windows, square root, CORDIC, blend.
`default_nettype none

module imu_tcf_dp #(
    parameter int MEDIAN_LENGTH = 11,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  imu_tcf_pkg::t_cmd                    i_cmd,
    input  wire                                  i_cfg_we,
    input  wire [imu_tcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [imu_tcf_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire signed [15:0]                    i_gyro_x,
    input  wire signed [15:0]                    i_gyro_y,
    input  wire signed [15:0]                    i_gyro_z,
    input  wire signed [15:0]                    i_accel_x,
    input  wire signed [15:0]                    i_accel_y,
    input  wire signed [15:0]                    i_accel_z,
    input  wire [15:0]                           i_elapsed_us,
    output logic signed [15:0]                   o_angle_x,
    output logic signed [15:0]                   o_angle_y,
    output logic signed [15:0]                   o_rate_x,
    output logic signed [15:0]                   o_rate_y,
    output logic signed [15:0]                   o_rate_z
);
    import imu_tcf_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int ML    = MEDIAN_LENGTH;
    localparam int IW    = $clog2(ML);
    localparam int CW_N  = $clog2(ML + 1);
    localparam int KMED  = ML / 2;
    localparam int SQ_W  = 2 * SW;
    localparam int CI_W  = SW + 2;
    localparam int CW    = SW + 20;
    localparam logic signed [24:0] S_HI = 25'((1 << (SW - 1)) - 1);
    localparam logic signed [24:0] S_LO = 25'(-(1 << (SW - 1)));

    // Configuration registers.
    logic signed [15:0] r_gofs [3];
    logic signed [15:0] r_aofs [3];
    logic [15:0]        r_gw, r_aw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_gofs[a] <= '0;
                r_aofs[a] <= '0;
            end
            r_gw <= GYRO_WEIGHT_RST;
            r_aw <= ACCEL_WEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GYRO_OFS_X:   r_gofs[0] <= i_cfg_data;
                CFG_GYRO_OFS_Y:   r_gofs[1] <= i_cfg_data;
                CFG_GYRO_OFS_Z:   r_gofs[2] <= i_cfg_data;
                CFG_ACCEL_OFS_X:  r_aofs[0] <= i_cfg_data;
                CFG_ACCEL_OFS_Y:  r_aofs[1] <= i_cfg_data;
                CFG_ACCEL_OFS_Z:  r_aofs[2] <= i_cfg_data;
                CFG_GYRO_WEIGHT:  r_gw      <= i_cfg_data;
                CFG_ACCEL_WEIGHT: r_aw      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Offset correction at the input beat.
    logic signed [15:0]   gyro_in [3];
    logic signed [15:0]   acc_in  [3];
    logic signed [15:0]   rate_c  [3];
    logic signed [SW-1:0] samp_c  [3];

    assign gyro_in[0] = i_gyro_x;
    assign gyro_in[1] = i_gyro_y;
    assign gyro_in[2] = i_gyro_z;
    assign acc_in[0]  = i_accel_x;
    assign acc_in[1]  = i_accel_y;
    assign acc_in[2]  = i_accel_z;

    always_comb begin
        logic signed [16:0] gs, as;
        logic signed [24:0] ae;
        for (int a = 0; a < 3; a++) begin
            gs = {gyro_in[a][15], gyro_in[a]} + {r_gofs[a][15], r_gofs[a]};
            if (gs[16] != gs[15]) begin
                rate_c[a] = gs[16] ? 16'sh8000 : 16'sh7fff;
            end else begin
                rate_c[a] = gs[15:0];
            end
            as = {acc_in[a][15], acc_in[a]} + {r_aofs[a][15], r_aofs[a]};
            ae = {{8{as[16]}}, as};
            if (ae > S_HI) begin
                ae = S_HI;
            end else if (ae < S_LO) begin
                ae = S_LO;
            end
            samp_c[a] = ae[SW-1:0];
        end
    end

    // Median windows and per-item registers.
    logic signed [SW-1:0] r_win [3][ML];
    logic [IW-1:0]        r_pos;
    logic signed [15:0]   r_rate [3];
    logic [15:0]          r_dt;
    logic signed [SW-1:0] r_med [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                for (int j = 0; j < ML; j++) begin
                    r_win[a][j] <= '0;
                end
            end
            r_pos <= '0;
        end else if (i_cmd.accept) begin
            for (int a = 0; a < 3; a++) begin
                r_win[a][r_pos] <= samp_c[a];
            end
            r_pos <= (r_pos == IW'(ML - 1)) ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int a = 0; a < 3; a++) begin
                r_rate[a] <= rate_c[a];
            end
            r_dt <= i_elapsed_us;
        end
    end

    // One candidate per cycle is ranked against the whole window.
    logic signed [SW-1:0] cand [3];
    logic [2:0]           hit;

    always_comb begin
        logic [ML-1:0]   lt, eq;
        logic [CW_N-1:0] n_lt, n_eq;
        for (int a = 0; a < 3; a++) begin
            cand[a] = r_win[a][i_cmd.cnt[IW-1:0]];
            for (int j = 0; j < ML; j++) begin
                lt[j] = (r_win[a][j] < cand[a]);
                eq[j] = (r_win[a][j] == cand[a]);
            end
            n_lt   = CW_N'($countones(lt));
            n_eq   = CW_N'($countones(eq));
            hit[a] = (n_lt <= KMED) && (KMED < (n_lt + n_eq));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.med_step) begin
            for (int a = 0; a < 3; a++) begin
                if (hit[a]) begin
                    r_med[a] <= cand[a];
                end
            end
        end
    end

    // Bit-serial integer square root of my^2 + mz^2.
    logic [SQ_W-1:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [SQ_W-1:0] ye, ze, sq_try;

    assign ye     = {{SW{r_med[1][SW-1]}}, r_med[1]};
    assign ze     = {{SW{r_med[2][SW-1]}}, r_med[2]};
    assign sq_try = r_sq_res + r_sq_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.roll_init) begin
            r_sq_v   <= ye * ye + ze * ze;
            r_sq_res <= '0;
            r_sq_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (i_cmd.sq_step) begin
            if (r_sq_v >= sq_try) begin
                r_sq_v   <= r_sq_v - sq_try;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    // Shared vectoring CORDIC, roll first and pitch second.
    logic signed [CW-1:0]    r_cx, r_cy;
    logic signed [ANG_W-1:0] r_cz;
    logic signed [16:0]      r_roll;
    logic signed [CI_W-1:0]  ci_y, ci_x, f_y, f_x;
    logic signed [ANG_W-1:0] f_z, z_rnd;
    logic signed [CW-1:0]    e_x, e_y, sx, sy;
    logic signed [16:0]      c_ang;

    always_comb begin
        if (i_cmd.pitch_init) begin
            ci_y = -{{2{r_med[0][SW-1]}}, r_med[0]};
            ci_x = {2'b00, r_sq_res[SW-1:0]};
        end else begin
            ci_y = {{2{r_med[1][SW-1]}}, r_med[1]};
            ci_x = {{2{r_med[2][SW-1]}}, r_med[2]};
        end
        if (ci_x < 0) begin
            f_z = (ci_y >= 0) ? HALF_TURN : -HALF_TURN;
            f_x = -ci_x;
            f_y = -ci_y;
        end else begin
            f_z = '0;
            f_x = ci_x;
            f_y = ci_y;
        end
        e_x = {{(CW - CI_W){f_x[CI_W-1]}}, f_x} <<< 16;
        e_y = {{(CW - CI_W){f_y[CI_W-1]}}, f_y} <<< 16;
        sx  = r_cx >>> i_cmd.cnt;
        sy  = r_cy >>> i_cmd.cnt;
        z_rnd = r_cz + 26'sd256;
        c_ang = $signed(z_rnd[ANG_W-1:9]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.roll_init || i_cmd.pitch_init) begin
            r_cx <= e_x;
            r_cy <= e_y;
            r_cz <= f_z;
        end else if (i_cmd.roll_step || i_cmd.pitch_step) begin
            if (r_cy > 0) begin
                r_cx <= r_cx + sy;
                r_cy <= r_cy - sx;
                r_cz <= r_cz + atan_entry(i_cmd.cnt);
            end else if (r_cy < 0) begin
                r_cx <= r_cx - sy;
                r_cy <= r_cy + sx;
                r_cz <= r_cz - atan_entry(i_cmd.cnt);
            end
        end
        if (i_cmd.pitch_init) begin
            r_roll <= c_ang;
        end
    end

    // Blend: gyro prediction and accelerometer angle, then the division by
    // the constant denominator as a shift, a clamp and a reciprocal multiply.
    logic signed [15:0]  r_fused [2];
    logic [P_W-1:0]      r_p   [2];
    logic [T_W-1:0]      r_t   [2];
    logic [N_W-1:0]      r_m1  [2];
    logic [N_W-1:0]      r_m2  [2];
    logic [N_W-1:0]      r_num [2];
    logic [U_W-1:0]      r_u   [2];
    logic [Q_W-1:0]      r_q   [2];
    logic [U_W-1:0]      u_c   [2];
    logic [Q_W-1:0]      q_c   [2];
    logic signed [15:0]  q_sat [2];
    logic signed [15:0]  r_o_ang  [2];
    logic signed [15:0]  r_o_rate [3];

    always_comb begin
        logic signed [M_W-1:0]       m_v, m_c, m_u;
        logic [U_W+RECIP_W-1:0]      prod;
        logic signed [Q_W:0]         qs;
        for (int ax = 0; ax < 2; ax++) begin
            // Floor of the numerator over 2^20, then offset to be positive.
            m_v = $signed(r_num[ax][N_W-1:N_W-M_W]);
            if (m_v > M_HI) begin
                m_c = M_HI;
            end else if (m_v < M_LO) begin
                m_c = M_LO;
            end else begin
                m_c = m_v;
            end
            m_u     = m_c - M_LO;
            u_c[ax] = m_u[U_W-1:0];
            // Exact division by 15625 over the whole offset range.
            prod    = {{RECIP_W{1'b0}}, r_u[ax]} * {{U_W{1'b0}}, RECIP};
            q_c[ax] = prod[RECIP_SH+Q_W-1:RECIP_SH];
            qs = $signed({1'b0, r_q[ax]}) - $signed({1'b0, Q_BIAS});
            if (qs > 18'sd32767) begin
                q_sat[ax] = 16'sh7fff;
            end else if (qs < -18'sd32768) begin
                q_sat[ax] = 16'sh8000;
            end else begin
                q_sat[ax] = qs[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fused[0] <= '0;
            r_fused[1] <= '0;
        end else if (i_cmd.commit) begin
            r_fused[0] <= q_sat[0];
            r_fused[1] <= q_sat[1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [16:0] acc;
        logic [P_W-1:0]     f_e, r_e;
        logic [T_W-1:0]     a_e;
        for (int ax = 0; ax < 2; ax++) begin
            acc = (ax == 0) ? r_roll : c_ang;
            f_e = {{(P_W - 16){r_fused[ax][15]}}, r_fused[ax]};
            r_e = {{(P_W - 16){r_rate[ax][15]}}, r_rate[ax]};
            a_e = {{(T_W - 17){acc[16]}}, acc};
            if (i_cmd.bl0) begin
                r_p[ax] <= f_e * DT_DIV[P_W-1:0] + r_e * {{(P_W - 16){1'b0}}, r_dt};
                r_t[ax] <= {{(T_W - 16){1'b0}}, r_aw} * a_e;
            end
            if (i_cmd.bl1) begin
                r_m1[ax] <= {{(N_W - 16){1'b0}}, r_gw} *
                            {{(N_W - P_W){r_p[ax][P_W-1]}}, r_p[ax]};
                r_m2[ax] <= {{(N_W - T_W){r_t[ax][T_W-1]}}, r_t[ax]} * DT_DIV;
            end
            if (i_cmd.bl2) begin
                r_num[ax] <= r_m1[ax] + r_m2[ax] + DEN_HALF;
            end
            // Two steps: the first loads the offset numerator, the second the quotient.
            if (i_cmd.div_step) begin
                r_u[ax] <= u_c[ax];
                r_q[ax] <= q_c[ax];
            end
        end
        if (i_cmd.commit) begin
            r_o_ang[0] <= q_sat[0];
            r_o_ang[1] <= q_sat[1];
            for (int a = 0; a < 3; a++) begin
                r_o_rate[a] <= r_rate[a];
            end
        end
    end

    assign o_angle_x = r_o_ang[0];
    assign o_angle_y = r_o_ang[1];
    assign o_rate_x  = r_o_rate[0];
    assign o_rate_y  = r_o_rate[1];
    assign o_rate_z  = r_o_rate[2];

endmodule

`default_nettype wire

// ===== src/imu_tilt_complementary_filter.sv =====
// Top level of the IMU tilt complementary filter.
//
// One input beat carries one IMU sample: three gyro rates (Q10.6 deg/s),
// three accelerometer counts and the time step in microseconds. Each input
// beat yields exactly one output beat with the fused roll and pitch angles
// in 1/128 degree and the three offset-corrected rates.
// Both channels use valid/ready. The block takes one sample at a time: the
// input ready is high only while the sequencer is idle. Between the input
// beat and the output valid the sequencer runs the rank search over the
// median window, loads the shared CORDIC for roll and runs it beside the
// bit-serial square root, loads the same unit for pitch and runs it, then
// forms the three blend products, does a two-step reciprocal division and
// commits, after which it returns to idle.
// The result sits in an output register, so a new sample is accepted while
// an earlier result waits; if the receiver stalls, the next result is held
// in the datapath until that register frees up.
// Reset (synchronous, active low) clears the median windows to zero, the
// window position and both fused angles, and loads the default weights.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module imu_tilt_complementary_filter #(
    parameter int MEDIAN_LENGTH = 11,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [imu_tcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [imu_tcf_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire signed [15:0]                 i_gyro_x,
    input  wire signed [15:0]                 i_gyro_y,
    input  wire signed [15:0]                 i_gyro_z,
    input  wire signed [15:0]                 i_accel_x,
    input  wire signed [15:0]                 i_accel_y,
    input  wire signed [15:0]                 i_accel_z,
    input  wire [15:0]                        i_elapsed_us,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic signed [15:0]                o_angle_x,
    output logic signed [15:0]                o_angle_y,
    output logic signed [15:0]                o_rate_x,
    output logic signed [15:0]                o_rate_y,
    output logic signed [15:0]                o_rate_z
);
    import imu_tcf_pkg::*;

    t_cmd cmd;

    // The sequencer issues one command word per cycle to the datapath.
    imu_tcf_ctrl #(
        .MEDIAN_LENGTH (MEDIAN_LENGTH),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, filter state and output register.
    imu_tcf_dp #(
        .MEDIAN_LENGTH (MEDIAN_LENGTH),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_gyro_x     (i_gyro_x),
        .i_gyro_y     (i_gyro_y),
        .i_gyro_z     (i_gyro_z),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_elapsed_us (i_elapsed_us),
        .o_angle_x    (o_angle_x),
        .o_angle_y    (o_angle_y),
        .o_rate_x     (o_rate_x),
        .o_rate_y     (o_rate_y),
        .o_rate_z     (o_rate_z)
    );

endmodule

`default_nettype wire

// ===== src/imu_tcf_checker.sv =====
// Port-level assertions for the IMU tilt filter, bound to the top level.
`default_nettype none

module imu_tcf_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_ready,
    input wire               o_out_valid,
    input wire               i_out_ready,
    input wire signed [15:0] o_angle_x,
    input wire signed [15:0] o_angle_y,
    input wire signed [15:0] o_rate_x
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_angle_x) && $stable(o_angle_y) && $stable(o_rate_x)))
        else $error("output beat changed while stalled");

    // After an input beat the block is busy and the input ready stays low.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready ##1 !o_in_ready)
        else $error("input accepted again too early");

    // A result never appears in the cycle right after an input beat.
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result appeared too soon");

    // Reset leaves the block idle with no pending result.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

endmodule

bind imu_tilt_complementary_filter imu_tcf_checker u_chk (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the IMU tilt complementary filter.
`timescale 1ns / 1ps

module testbench;
    import imu_tcf_pkg::*;

    // Median window depth and the longest gap without any accepted beat.
    localparam int WIN       = 11;
    localparam int STALL_MAX = 20000;

    // One IMU sample as it is driven onto the input port.
    typedef struct {
        logic signed [15:0] gx, gy, gz, ax, ay, az;
        logic [15:0]        dt;
    } sample_t;

    // One filter result as it appears on the output port.
    typedef struct {
        logic signed [15:0] ang_x, ang_y, rt_x, rt_y, rt_z;
    } tilt_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic signed [15:0]    i_gyro_x = '0, i_gyro_y = '0, i_gyro_z = '0;
    logic signed [15:0]    i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic [15:0]           i_elapsed_us = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [15:0]    o_angle_x, o_angle_y, o_rate_x, o_rate_y, o_rate_z;

    imu_tilt_complementary_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_gyro_x(i_gyro_x), .i_gyro_y(i_gyro_y), .i_gyro_z(i_gyro_z),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_elapsed_us(i_elapsed_us),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_angle_x(o_angle_x), .o_angle_y(o_angle_y), .o_rate_x(o_rate_x),
        .o_rate_y(o_rate_y), .o_rate_z(o_rate_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the filter's registers and state.
    longint ofs_gyro[3];
    longint ofs_accel[3];
    longint wt_gyro, wt_accel;
    longint win_x[WIN], win_y[WIN], win_z[WIN];
    int     win_pos;
    longint fused_roll, fused_pitch;

    sample_t sample_queue[$];
    tilt_t   tilt_queue[$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      stim_done = 1'b0;

    // atan(2^-i) in 2^-16 degree, one entry per CORDIC step.
    longint atan_lut[CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

    function automatic longint clamp(longint v, int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
    endfunction

    // Floor division for a positive divisor: SystemVerilog / truncates toward zero.
    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q -= 1;
        return q;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res, bit_v;
        res = 0;
        bit_v = longint'(1) << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC for atan2(y, x), returned in 1/128 degree.
    function automatic longint tilt_atan2(longint y, longint x);
        longint ang, nx, ny;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                ang += atan_lut[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                ang -= atan_lut[i];
            end
            x = nx;
            y = ny;
        end
        return (ang + 256) >>> 9;
    endfunction

    // Middle element of a window, ranked by counting smaller entries.
    function automatic longint window_median(longint w[WIN]);
        int less, same;
        for (int i = 0; i < WIN; i++) begin
            less = 0;
            same = 0;
            for (int j = 0; j < WIN; j++) begin
                if (w[j] < w[i]) less++;
                else if (w[j] == w[i]) same++;
            end
            if (less <= WIN / 2 && WIN / 2 < less + same) return w[i];
        end
        return 0;
    endfunction

    function automatic longint fuse(longint prev, longint rate, longint dt, longint acc);
        longint p, den, num;
        p = prev * 500000 + rate * dt;
        den = longint'(500000) * 32768;
        num = wt_gyro * p + wt_accel * acc * 500000;
        return clamp(fdiv(num + den / 2, den), 16);
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < 3; i++) begin
            ofs_gyro[i] = 0;
            ofs_accel[i] = 0;
        end
        wt_gyro = GYRO_WEIGHT_RST;
        wt_accel = ACCEL_WEIGHT_RST;
        for (int i = 0; i < WIN; i++) begin
            win_x[i] = 0;
            win_y[i] = 0;
            win_z[i] = 0;
        end
        win_pos = 0;
        fused_roll = 0;
        fused_pitch = 0;
    endfunction

    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_GYRO_OFS_X:   ofs_gyro[0] = longint'($signed(val));
            CFG_GYRO_OFS_Y:   ofs_gyro[1] = longint'($signed(val));
            CFG_GYRO_OFS_Z:   ofs_gyro[2] = longint'($signed(val));
            CFG_ACCEL_OFS_X:  ofs_accel[0] = longint'($signed(val));
            CFG_ACCEL_OFS_Y:  ofs_accel[1] = longint'($signed(val));
            CFG_ACCEL_OFS_Z:  ofs_accel[2] = longint'($signed(val));
            CFG_GYRO_WEIGHT:  wt_gyro = longint'(val);
            CFG_ACCEL_WEIGHT: wt_accel = longint'(val);
            default: ;
        endcase
    endfunction

    // Advances the shadow state by one sample and returns the fused result.
    function automatic tilt_t predict_tilt(sample_t s);
        tilt_t  t;
        longint rx, ry, rz, mx, my, mz, roll, pitch, mag;
        rx = clamp(longint'(s.gx) + ofs_gyro[0], 16);
        ry = clamp(longint'(s.gy) + ofs_gyro[1], 16);
        rz = clamp(longint'(s.gz) + ofs_gyro[2], 16);
        win_x[win_pos] = clamp(longint'(s.ax) + ofs_accel[0], 16);
        win_y[win_pos] = clamp(longint'(s.ay) + ofs_accel[1], 16);
        win_z[win_pos] = clamp(longint'(s.az) + ofs_accel[2], 16);
        win_pos = (win_pos + 1 >= WIN) ? 0 : win_pos + 1;
        mx = window_median(win_x);
        my = window_median(win_y);
        mz = window_median(win_z);
        roll = tilt_atan2(my, mz);
        mag = int_sqrt(my * my + mz * mz);
        pitch = tilt_atan2(-mx, mag);
        fused_roll = fuse(fused_roll, rx, longint'(s.dt), roll);
        fused_pitch = fuse(fused_pitch, ry, longint'(s.dt), pitch);
        t.ang_x = fused_roll[15:0];
        t.ang_y = fused_pitch[15:0];
        t.rt_x = rx[15:0];
        t.rt_y = ry[15:0];
        t.rt_z = rz[15:0];
        return t;
    endfunction

    // Driver: takes the next sample from the queue after a random gap and
    // holds it on the port until the beat is accepted.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tilt_queue.push_back(predict_tilt(sample_queue.pop_front()));
                i_in_valid <= 1'b0;
                send_gap = $urandom_range(0, 4);
            end else if (!i_in_valid && sample_queue.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    i_gyro_x <= sample_queue[0].gx;
                    i_gyro_y <= sample_queue[0].gy;
                    i_gyro_z <= sample_queue[0].gz;
                    i_accel_x <= sample_queue[0].ax;
                    i_accel_y <= sample_queue[0].ay;
                    i_accel_z <= sample_queue[0].az;
                    i_elapsed_us <= sample_queue[0].dt;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks each output beat against the oldest prediction and
    // throttles the output ready with a random stall per beat.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        tilt_t exp_t;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (tilt_queue.size() == 0) begin
                    $error("output beat with nothing expected");
                    errors++;
                end else begin
                    exp_t = tilt_queue.pop_front();
                    if (o_angle_x !== exp_t.ang_x) begin
                        $error("angle_x: expected %0d, got %0d", exp_t.ang_x, o_angle_x);
                        errors++;
                    end
                    if (o_angle_y !== exp_t.ang_y) begin
                        $error("angle_y: expected %0d, got %0d", exp_t.ang_y, o_angle_y);
                        errors++;
                    end
                    if (o_rate_x !== exp_t.rt_x) begin
                        $error("rate_x: expected %0d, got %0d", exp_t.rt_x, o_rate_x);
                        errors++;
                    end
                    if (o_rate_y !== exp_t.rt_y) begin
                        $error("rate_y: expected %0d, got %0d", exp_t.rt_y, o_rate_y);
                        errors++;
                    end
                    if (o_rate_z !== exp_t.rt_z) begin
                        $error("rate_z: expected %0d, got %0d", exp_t.rt_z, o_rate_z);
                        errors++;
                    end
                end
                recv_gap = $urandom_range(0, 4);
                i_out_ready <= (recv_gap == 0);
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= (recv_gap == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a correct run never goes this long without an accepted beat.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        shadow_write(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued sample has been sent and checked, then lets
    // the datapath settle before the registers change.
    task automatic drain();
        while (sample_queue.size() > 0 || i_in_valid || tilt_queue.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic sample_t make_sample(logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                                            logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                            logic [15:0] dt);
        sample_t s;
        s.gx = gx; s.gy = gy; s.gz = gz;
        s.ax = ax; s.ay = ay; s.az = az;
        s.dt = dt;
        return s;
    endfunction

    // Random sample: mostly a plausible tilt with noise, sometimes full range.
    function automatic sample_t rand_sample();
        sample_t s;
        int      g;
        s = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) != 0) begin
            g = $urandom_range(0, 20000);
            s.ax = $urandom_range(0, 2 * g) - g;
            s.ay = $urandom_range(0, 2 * g) - g;
            s.az = $urandom_range(0, 2 * g) - g;
            s.gx = $urandom_range(0, 8000) - 4000;
            s.gy = $urandom_range(0, 8000) - 4000;
            s.dt = $urandom_range(0, 4000);
        end
        return s;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) sample_queue.push_back(rand_sample());
        drain();
    endtask

    initial begin
        reset_shadow();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: level, extremes of every field, zero vectors, and axes
        // that put the CORDIC on a negative x or an exact zero y.
        sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 16384, 2000));
        sample_queue.push_back(make_sample(16'h7fff, 16'h8000, 16'h7fff,
                                           16'h7fff, 16'h7fff, 16'h7fff, 16'hffff));
        sample_queue.push_back(make_sample(16'h8000, 16'h7fff, 16'h8000,
                                           16'h8000, 16'h8000, 16'h8000, 16'hffff));
        for (int i = 0; i < 7; i++)
            sample_queue.push_back(make_sample(100, -100, 5, -16384, 0, -16384, 1000));
        for (int i = 0; i < 7; i++)
            sample_queue.push_back(make_sample(-1, 1, -1, 16384, -16384, 0, 1));
        drain();

        random_phase(300);

        // Offsets at the positive extreme with heavy weights that saturate.
        cfg_write(CFG_GYRO_OFS_X, 16'h7fff);
        cfg_write(CFG_GYRO_OFS_Y, 16'h7fff);
        cfg_write(CFG_GYRO_OFS_Z, 16'h7fff);
        cfg_write(CFG_ACCEL_OFS_X, 16'h7fff);
        cfg_write(CFG_ACCEL_OFS_Y, 16'h7fff);
        cfg_write(CFG_ACCEL_OFS_Z, 16'h7fff);
        cfg_write(CFG_GYRO_WEIGHT, 16'hffff);
        cfg_write(CFG_ACCEL_WEIGHT, 16'hffff);
        random_phase(250);

        // Offsets at the negative extreme, pure accelerometer tracking.
        cfg_write(CFG_GYRO_OFS_X, 16'h8000);
        cfg_write(CFG_GYRO_OFS_Y, 16'h8000);
        cfg_write(CFG_GYRO_OFS_Z, 16'h8000);
        cfg_write(CFG_ACCEL_OFS_X, 16'h8000);
        cfg_write(CFG_ACCEL_OFS_Y, 16'h8000);
        cfg_write(CFG_ACCEL_OFS_Z, 16'h8000);
        cfg_write(CFG_GYRO_WEIGHT, 16'd0);
        cfg_write(CFG_ACCEL_WEIGHT, 16'd32768);
        random_phase(250);

        // Pure gyro integration with zero accelerometer weight.
        cfg_write(CFG_GYRO_WEIGHT, 16'd32768);
        cfg_write(CFG_ACCEL_WEIGHT, 16'd0);
        random_phase(250);

        // Random register settings between phases.
        for (int ph = 0; ph < 3; ph++) begin
            for (int r = 0; r < 6; r++)
                cfg_write(r[CFG_IDX_W-1:0], $urandom_range(0, 4000) - 2000);
            cfg_write(CFG_GYRO_WEIGHT, $urandom_range(0, 32768));
            cfg_write(CFG_ACCEL_WEIGHT, $urandom_range(0, 32768));
            random_phase(230);
        end

        stim_done = 1'b1;
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/imu_tcf_pkg.sv
src/imu_tcf_ctrl.sv
src/imu_tcf_dp.sv
src/imu_tilt_complementary_filter.sv
src/imu_tcf_checker.sv
test/testbench.sv
